/* rtl/core/bnm_pkg.sv */
// Shared constants, types and helpers for the nearest barcode matcher.
`default_nettype none

package bnm_pkg;

	// Default table depth and read index length
	localparam int DEF_MAX_ENTRIES = 64;
	localparam int DEF_MAX_BASES   = 16;

	// Fixed field widths of the words
	localparam int BASE_W     = 3;
	localparam int SLOT_W     = 6;
	localparam int LEN_W      = 5;
	localparam int ALLOW_W    = 5;
	localparam int ECOUNT_W   = 7;
	localparam int MISMATCH_W = 5;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	// Register reset values
	localparam logic [LEN_W-1:0]    USED_LENGTH_RST = LEN_W'(8);
	localparam logic [ECOUNT_W-1:0] ENTRY_COUNT_RST = '0;

	// Base code that every non-ACGT code folds to
	localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

	// Word kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USED_LENGTH = 1'b0,
		REG_ENTRY_COUNT = 1'b1
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	// Fold base codes five to seven onto "other"
	function automatic logic [BASE_W-1:0] norm_base(input logic [BASE_W-1:0] code);
		norm_base = (code > BASE_OTHER) ? BASE_OTHER : code;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/bnm_if.sv */
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface bnm_req_if import bnm_pkg::*; #(
	parameter int N_BASES = DEF_MAX_BASES
);
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [SLOT_W-1:0]         entry_index;
	logic [BASE_W*N_BASES-1:0] bases;
	logic [ALLOW_W-1:0]        allowed_mismatches;

	modport source (output valid, kind, entry_index, bases, allowed_mismatches,
		input ready);
	modport sink (input valid, kind, entry_index, bases, allowed_mismatches,
		output ready);
endinterface

interface bnm_rsp_if import bnm_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  matched;
	logic [SLOT_W-1:0]     sample_slot;
	logic [MISMATCH_W-1:0] mismatch_count;

	modport source (output valid, matched, sample_slot, mismatch_count, input ready);
	modport sink (input valid, matched, sample_slot, mismatch_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/bnm_store.sv */
// Barcode and allowance table: one write port, one registered read port.
`default_nettype none

module bnm_store import bnm_pkg::*; #(
	parameter int DEPTH  = DEF_MAX_ENTRIES,
	parameter int WIDTH  = BASE_W * DEF_MAX_BASES + ALLOW_W,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write a loaded entry, read one entry per cycle during a scan
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bnm_dist.sv */
// Mismatch counter: compares one stored barcode with the query over the used length.
`default_nettype none

module bnm_dist import bnm_pkg::*; #(
	parameter int N_BASES = DEF_MAX_BASES,
	parameter int CNT_W   = $clog2(N_BASES + 1)
) (
	input  wire logic [BASE_W*N_BASES-1:0] a,
	input  wire logic [BASE_W*N_BASES-1:0] b,
	input  wire logic [LEN_W-1:0]          len,
	output logic      [CNT_W-1:0]          cnt
);

	logic [N_BASES-1:0] mism;

	// Flag each position inside the length whose folded codes differ
	always_comb begin
		for (int i = 0; i < N_BASES; i++) begin
			mism[i] = (LEN_W'(i) < len) &&
				(norm_base(a[BASE_W*i +: BASE_W]) != norm_base(b[BASE_W*i +: BASE_W]));
		end
	end

	// Population count of the flags
	assign cnt = CNT_W'($countones(mism));

endmodule

`default_nettype wire

/* rtl/core/barcode_nearest_match.sv */
// Top level of the nearest barcode matcher: sequencer, best-entry tracker, result register.
`default_nettype none

// A load word writes one table slot; the block is ready again in the next cycle.
// A query word scans slots 0 to entry_count-1 through a single table read port
// and one shared mismatch counter, one slot per cycle, before its response word is
// offered. The response sits in an output register, so the next word is accepted
// while it waits; a query that finishes while the previous response is still
// untaken waits for it. The table has no reset: query only slots that were loaded.
// Configuration is to be written only while the block is idle; the block itself
// does not enforce it.
module barcode_nearest_match import bnm_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int MAX_BASES   = DEF_MAX_BASES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bnm_req_if.sink                    req,
	bnm_rsp_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BW     = BASE_W * MAX_BASES;
	localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW     = $clog2(MAX_ENTRIES + 1);
	localparam int MW     = $clog2(MAX_BASES + 1);
	localparam int ROW_W  = BW + ALLOW_W;

	state_t state_q;

	logic [LEN_W-1:0]    used_length_q;
	logic [ECOUNT_W-1:0] entry_count_q;

	logic [BW-1:0]       qbases_q;
	logic [LEN_W-1:0]    len_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       issue_q;
	logic                issuing_q;
	logic                vld_s1;
	logic                last_s1;
	logic [AW-1:0]       slot_s1;

	logic                have_q;
	logic                tie_q;
	logic [MW-1:0]       best_q;
	logic [AW-1:0]       best_slot_q;
	logic [ALLOW_W-1:0]  best_allow_q;

	logic                rsp_valid_q;
	logic                matched_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [MISMATCH_W-1:0] mm_q;

	logic                req_fire;
	logic                load_we;
	logic [LEN_W-1:0]    len_sat;
	logic [CW-1:0]       count_sat;
	logic                issue_last;
	logic [ROW_W-1:0]    rdata;
	logic [MW-1:0]       mm_cnt;
	logic                res_matched;
	logic                out_free;

	// Handshake
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Write loads that land inside the table
	assign load_we = req_fire && (req.kind == KIND_LOAD) &&
		(32'(req.entry_index) < MAX_ENTRIES);

	// Saturate length and entry count
	assign len_sat = (32'(used_length_q) > MAX_BASES) ? LEN_W'(MAX_BASES) : used_length_q;
	assign count_sat = (32'(entry_count_q) > MAX_ENTRIES) ?
		CW'(MAX_ENTRIES) : CW'(entry_count_q);

	assign issue_last = (CW'(issue_q) == (count_q - CW'(1)));

	bnm_store #(
		.DEPTH  (MAX_ENTRIES),
		.WIDTH  (ROW_W),
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(req.entry_index)),
		.wdata ({req.allowed_mismatches, req.bases}),
		.re    (issuing_q),
		.raddr (issue_q),
		.rdata (rdata)
	);

	bnm_dist #(
		.N_BASES (MAX_BASES),
		.CNT_W   (MW)
	) u_dist (
		.a   (qbases_q),
		.b   (rdata[BW-1:0]),
		.len (len_q),
		.cnt (mm_cnt)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_length_q <= USED_LENGTH_RST;
			entry_count_q <= ENTRY_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_USED_LENGTH: used_length_q <= cfg_data[LEN_W-1:0];
				REG_ENTRY_COUNT: entry_count_q <= cfg_data[ECOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequence the scan: issue reads, track the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issuing_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= issuing_q;
			case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.kind == KIND_QUERY)) begin
						if (count_sat == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q   <= ST_SCAN;
							issuing_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (issuing_q && issue_last) begin
						issuing_q <= 1'b0;
					end
					if (vld_s1 && last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					issuing_q <= 1'b0;
				end
			endcase
		end
	end

	// Latch the query and advance the read address
	always_ff @(posedge clk) begin
		if (req_fire && (req.kind == KIND_QUERY)) begin
			qbases_q <= req.bases;
			len_q    <= len_sat;
			count_q  <= count_sat;
			issue_q  <= '0;
		end else if (issuing_q && !issue_last) begin
			issue_q <= issue_q + AW'(1);
		end
		last_s1 <= issue_last;
		slot_s1 <= issue_q;
	end

	// Keep the lowest count seen, flag ties
	always_ff @(posedge clk) begin
		if (req_fire && (req.kind == KIND_QUERY)) begin
			have_q <= 1'b0;
			tie_q  <= 1'b0;
		end else if (vld_s1) begin
			if (!have_q || (mm_cnt < best_q)) begin
				have_q       <= 1'b1;
				tie_q        <= 1'b0;
				best_q       <= mm_cnt;
				best_slot_q  <= slot_s1;
				best_allow_q <= rdata[ROW_W-1:BW];
			end else if (mm_cnt == best_q) begin
				tie_q <= 1'b1;
			end
		end
	end

	assign res_matched = have_q && !tie_q && (MISMATCH_W'(best_q) <= best_allow_q);

	// Hold the response word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			matched_q <= res_matched;
			slot_q    <= res_matched ? SLOT_W'(best_slot_q) : '0;
			mm_q      <= res_matched ? MISMATCH_W'(best_q) : '0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.matched        = matched_q;
	assign rsp.sample_slot    = slot_q;
	assign rsp.mismatch_count = mm_q;

	// An unmatched response carries zero slot and zero count
	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.matched |-> (rsp.sample_slot == '0) && (rsp.mismatch_count == '0))
		else $error("unmatched response with nonzero payload");

	// The read address never passes the last searched slot
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> (CW'(issue_q) < count_q))
		else $error("scan read beyond searched entries");

	// A query blocks further words in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.kind == KIND_QUERY) |=> !req.ready)
		else $error("ready while a query is in flight");

	// Reads are issued only while scanning
	a_issue_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> (state_q == ST_SCAN))
		else $error("table read outside a scan");

endmodule

`default_nettype wire

/* tb/bnm_checker.sv */
// Checker for the nearest barcode matcher: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module bnm_checker import bnm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bnm_req_if                         req,
	bnm_rsp_if                         rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);
	localparam int TBL_DEPTH  = DEF_MAX_ENTRIES;
	localparam int READ_BASES = DEF_MAX_BASES;
	localparam int BASES_W    = BASE_W * READ_BASES;

	typedef struct packed {
		logic                  matched;
		logic [SLOT_W-1:0]     slot;
		logic [MISMATCH_W-1:0] count;
	} match_t;

	// Shadow of the barcode table and the two registers
	logic [BASES_W-1:0]  barcode_tbl [TBL_DEPTH];
	logic [ALLOW_W-1:0]  allow_tbl [TBL_DEPTH];
	logic [LEN_W-1:0]    used_len = USED_LENGTH_RST;
	logic [ECOUNT_W-1:0] entry_cnt = ENTRY_COUNT_RST;

	match_t match_q[$];
	int     fails = 0;
	int     waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	// Search the loaded slots for the unique nearest barcode
	function automatic match_t predict_match(input logic [BASES_W-1:0] read_bases);
		int                span;
		int                searched;
		int                diffs;
		int                best;
		int                best_slot;
		bit                have;
		bit                tie;
		logic [BASE_W-1:0] rb;
		logic [BASE_W-1:0] tb;
		match_t            res;
		span = (used_len > READ_BASES) ? READ_BASES : int'(used_len);
		searched = (entry_cnt > TBL_DEPTH) ? TBL_DEPTH : int'(entry_cnt);
		have = 1'b0;
		tie = 1'b0;
		best = 0;
		best_slot = 0;
		for (int e = 0; e < searched; e++) begin
			diffs = 0;
			for (int i = 0; i < span; i++) begin
				rb = read_bases[i*BASE_W +: BASE_W];
				tb = barcode_tbl[e][i*BASE_W +: BASE_W];
				// any two non-ACGT codes count as the same base
				if (!(rb == tb || (rb >= BASE_OTHER && tb >= BASE_OTHER)))
					diffs++;
			end
			if (!have || diffs < best) begin
				have = 1'b1;
				best = diffs;
				best_slot = e;
				tie = 1'b0;
			end else if (diffs == best) begin
				tie = 1'b1;
			end
		end
		res = '0;
		if (have && !tie && best <= allow_tbl[best_slot]) begin
			res.matched = 1'b1;
			res.slot = SLOT_W'(best_slot);
			res.count = MISMATCH_W'(best);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t bnm_checker: %s", $realtime, msg);
		fails++;
	endtask

	// Compare one response word against the oldest expectation
	task automatic check_result();
		match_t want;
		if (match_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result: matched=%0d slot=%0d count=%0d",
				rsp.matched, rsp.sample_slot, rsp.mismatch_count));
			return;
		end
		want = match_q.pop_front();
		if (rsp.matched !== want.matched)
			report_mismatch($sformatf("matched %0d, want %0d", rsp.matched, want.matched));
		if (rsp.sample_slot !== want.slot)
			report_mismatch($sformatf("sample_slot %0d, want %0d", rsp.sample_slot, want.slot));
		if (rsp.mismatch_count !== want.count)
			report_mismatch($sformatf("mismatch_count %0d, want %0d",
				rsp.mismatch_count, want.count));
	endtask

	// Track loads, queries, results and register writes at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_len = USED_LENGTH_RST;
			entry_cnt = ENTRY_COUNT_RST;
			match_q.delete();
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready) begin
				if (req.kind == KIND_LOAD) begin
					barcode_tbl[req.entry_index] = req.bases;
					allow_tbl[req.entry_index] = req.allowed_mismatches;
				end else begin
					match_q.push_back(predict_match(req.bases));
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_USED_LENGTH: used_len = cfg_data[LEN_W-1:0];
					REG_ENTRY_COUNT: entry_cnt = cfg_data[ECOUNT_W-1:0];
					default: ;
				endcase
			end
		end
		waiting = match_q.size();
	end

endmodule

/* tb/tb_top.sv */
// Testbench top for the nearest barcode matcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import bnm_pkg::*;

	localparam int READ_BASES     = DEF_MAX_BASES;
	localparam int TBL_DEPTH      = DEF_MAX_ENTRIES;
	localparam int BASES_W        = BASE_W * READ_BASES;
	localparam int IDLE_LIMIT     = 4000;
	localparam int SETTLE_CYCLES  = TBL_DEPTH + 16;
	localparam int SQUEEZE_CYCLES = 400;

	// Base codes
	localparam logic [BASE_W-1:0] BASE_A    = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C    = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G    = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T    = 3'd3;
	localparam logic [BASE_W-1:0] BASE_JUNK = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending;
	int                    idle_cycles = 0;
	int                    calm_left = 0;
	bit                    squeeze_go = 1'b0;
	logic [BASES_W-1:0]    shadow_bases [TBL_DEPTH];

	bnm_req_if #(.N_BASES(READ_BASES)) req_ch ();
	bnm_rsp_if rsp_ch ();

	barcode_nearest_match uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bnm_checker match_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: watchdog expired after %0d idle cycles", IDLE_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Pause length: mostly none or short, a few long
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// Response side: random stalls, one long hold-off while the sender keeps offering
	initial begin
		int  low;
		int  high;
		bit  squeezed;
		rsp_ch.ready = 1'b0;
		squeezed = 1'b0;
		wait (arst_n);
		forever begin
			if (squeeze_go && !squeezed) begin
				squeezed = 1'b1;
				low = SQUEEZE_CYCLES;
				high = 1;
			end else begin
				low = pick_pause();
				high = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			end
			repeat (low) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
			end
			repeat (high) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one word after a random gap and hold it until taken
	task automatic send_word(input logic kind, input logic [SLOT_W-1:0] idx,
			input logic [BASES_W-1:0] bases, input logic [ALLOW_W-1:0] allow);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = pick_pause();
			if ($urandom_range(0, 19) == 0)
				calm_left = $urandom_range(10, 40);
		end
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.entry_index <= idx;
		req_ch.bases <= bases;
		req_ch.allowed_mismatches <= allow;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic load_entry(input logic [SLOT_W-1:0] slot, input logic [BASES_W-1:0] bases,
			input logic [ALLOW_W-1:0] allow);
		shadow_bases[slot] = bases;
		send_word(KIND_LOAD, slot, bases, allow);
	endtask

	// Query fields that a query ignores still get random values
	task automatic query_read(input logic [BASES_W-1:0] bases);
		send_word(KIND_QUERY, SLOT_W'($urandom), bases, ALLOW_W'($urandom));
	endtask

	// Drop valid and wait until every result is in and the block has gone quiet
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(input logic [LEN_W-1:0] len, input logic [ECOUNT_W-1:0] count);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_USED_LENGTH;
		cfg_data <= CFG_DATA_W'(len);
		@(negedge clk);
		cfg_index <= REG_ENTRY_COUNT;
		cfg_data <= CFG_DATA_W'(count);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One setting, then a mix of loads, near-hit queries and noise queries
	task automatic run_phase(input logic [LEN_W-1:0] len, input logic [ECOUNT_W-1:0] count,
			input int words, input bit squeeze);
		int                 searched;
		int                 span;
		int                 pick;
		int                 pos;
		logic [BASES_W-1:0] b;
		apply_config(len, count);
		searched = (count > TBL_DEPTH) ? TBL_DEPTH : int'(count);
		span = (len > READ_BASES) ? READ_BASES : ((len == 0) ? 1 : int'(len));
		squeeze_go = squeeze;
		for (int n = 0; n < words; n++) begin
			pick = $urandom_range(0, 99);
			// only queries while the receiver holds off, so the block backs up
			if (squeeze && n < 40)
				pick = 50;
			if (pick < 25) begin
				// overwrite a slot; sometimes clone a searched one to force a tie
				if (searched > 0 && $urandom_range(0, 1) == 0)
					pos = $urandom_range(0, searched - 1);
				else
					pos = $urandom_range(0, TBL_DEPTH - 1);
				if (searched > 1 && $urandom_range(0, 3) == 0)
					b = shadow_bases[$urandom_range(0, searched - 1)];
				else
					b = BASES_W'({$urandom, $urandom});
				load_entry(SLOT_W'(pos), b, ($urandom_range(0, 9) == 0) ?
					ALLOW_W'($urandom) : ALLOW_W'($urandom_range(0, 4)));
			end else if (pick < 80 && searched > 0) begin
				// copy a searched barcode and disturb a few bases
				b = shadow_bases[$urandom_range(0, searched - 1)];
				repeat ($urandom_range(0, 3)) begin
					pos = $urandom_range(0, span - 1);
					b[pos*BASE_W +: BASE_W] = BASE_W'($urandom_range(0, 7));
				end
				query_read(b);
			end else begin
				query_read(BASES_W'({$urandom, $urandom}));
			end
		end
	endtask

	initial begin
		logic [BASES_W-1:0] b;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_LOAD;
		req_ch.entry_index = '0;
		req_ch.bases = '0;
		req_ch.allowed_mismatches = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table: nothing to search
		query_read({READ_BASES{BASE_JUNK}});
		load_entry(0, {READ_BASES{BASE_A}}, 0);
		load_entry(1, {READ_BASES{BASE_C}}, 16);
		load_entry(2, {READ_BASES{BASE_JUNK}}, '1);
		load_entry(3, {READ_BASES{BASE_T}}, 2);
		load_entry('1, BASES_W'({$urandom, $urandom}), 0);
		apply_config(LEN_W'(READ_BASES), 4);
		query_read({READ_BASES{BASE_A}});
		// codes four to seven all fold to the same base
		query_read({READ_BASES{BASE_OTHER}});
		query_read({READ_BASES{BASE_C}});
		// equally far from the all-A and all-C entries
		query_read({{8{BASE_C}}, {8{BASE_A}}});
		// one mismatch against an entry that allows none
		b = {READ_BASES{BASE_A}};
		b[5*BASE_W +: BASE_W] = BASE_C;
		query_read(b);
		// exactly at the allowance, then one past it
		b = {READ_BASES{BASE_T}};
		b[0 +: 2*BASE_W] = {BASE_G, BASE_A};
		query_read(b);
		b[2*BASE_W +: BASE_W] = BASE_C;
		query_read(b);
		// length above the base count saturates; every base differs
		load_entry(0, {READ_BASES{BASE_G}}, '1);
		apply_config('1, 1);
		query_read({READ_BASES{BASE_T}});
		query_read(BASES_W'({$urandom, $urandom}));
		// zero length: every searched entry scores zero
		apply_config(0, 4);
		query_read(BASES_W'({$urandom, $urandom}));
		apply_config(0, 1);
		query_read(BASES_W'({$urandom, $urandom}));

		// fill the whole table so any entry count is legal from here on
		for (int s = 0; s < TBL_DEPTH; s++)
			load_entry(SLOT_W'(s), BASES_W'({$urandom, $urandom}), ALLOW_W'($urandom_range(0, 5)));

		run_phase(LEN_W'(READ_BASES), ECOUNT_W'(TBL_DEPTH), 100, 1'b1);
		run_phase(1, ECOUNT_W'(TBL_DEPTH), 90, 1'b0);
		run_phase('1, '1, 90, 1'b0);
		run_phase(0, 10, 80, 1'b0);
		run_phase(5, 0, 40, 1'b0);
		run_phase(12, 33, 100, 1'b0);
		run_phase(LEN_W'($urandom_range(0, 31)), ECOUNT_W'($urandom_range(1, 127)), 100, 1'b0);
		run_phase(LEN_W'($urandom_range(1, 16)), ECOUNT_W'($urandom_range(1, 64)), 100, 1'b0);

		drain();
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
